// ===== src/prefix_lock_table_top_assert.svh =====
// assertion macros for the prefix lock table
// used by the modules that check their own control sequencing
`ifndef PREFIX_LOCK_TABLE_TOP_ASSERT_SVH
`define PREFIX_LOCK_TABLE_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define PLT_ASSERT_SAME(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define PLT_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/plt_pkg.sv =====
// types, constants and codes for the prefix lock table
// no dependencies
`timescale 1ns / 1ps

package plt_pkg;

    localparam int TABLE_ENTRIES  = 64;
    localparam int IDX_W          = $clog2(TABLE_ENTRIES);
    localparam int LIVE_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int REFCOUNT_BITS  = 16;
    localparam int PRUNE_MIN_LIVE = 2;

    localparam logic [2:0] OP_SH_ACQ = 3'd0;
    localparam logic [2:0] OP_EX_ACQ = 3'd1;
    localparam logic [2:0] OP_SH_REL = 3'd2;
    localparam logic [2:0] OP_EX_REL = 3'd3;
    localparam logic [2:0] OP_PRUNE  = 3'd4;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_CANCELED = 3'd1;
    localparam logic [2:0] STS_BUSY     = 3'd2;
    localparam logic [2:0] STS_NOSPACE  = 3'd3;
    localparam logic [2:0] STS_INVALID  = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] key_hash;
        logic [63:0] txn_start;
        logic [63:0] txn_end;
        logic [5:0]  slot;
        logic        holds_shared;
        logic [63:0] horizon;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] granted_slot;
        logic [6:0] pruned_count;
    } t_out;

    typedef struct packed {
        logic [63:0]              key;
        logic [REFCOUNT_BITS-1:0] refcount;
        logic                     exclusive;
        logic                     stale;
        logic [63:0]              end_seq;
        logic [63:0]              end_excl;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDSLOT,
        ST_SCAN,
        ST_LAST,
        ST_UPDATE,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic             capture;
        logic             rd_en;
        logic             rd_slot;
        logic [IDX_W-1:0] rd_addr;
        logic             update;
    } t_cmd;

    typedef struct packed {
        logic live_ge_min;
    } t_stat;

endpackage

// ===== src/plt_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module plt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/plt_ctrl.sv =====
// sequencer for the prefix lock table: scan counter and operation steps
// depends on plt_pkg and prefix_lock_table_top_assert.svh
`timescale 1ns / 1ps
`include "prefix_lock_table_top_assert.svh"

module plt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [2:0]    i_opcode,
    input  logic          i_out_ready,
    input  plt_pkg::t_stat i_stat,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output plt_pkg::t_cmd o_cmd
);

    localparam logic [plt_pkg::IDX_W-1:0] LAST_IDX =
        plt_pkg::IDX_W'(plt_pkg::TABLE_ENTRIES - 1);

    plt_pkg::t_state r_state, n_state;
    logic [plt_pkg::IDX_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plt_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_in_ready  = (r_state == plt_pkg::ST_IDLE);
        o_out_valid = (r_state == plt_pkg::ST_RESP);
        case (r_state)
            plt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_cnt         = '0;
                    case (i_opcode)
                        plt_pkg::OP_SH_ACQ, plt_pkg::OP_EX_ACQ: n_state = plt_pkg::ST_SCAN;
                        plt_pkg::OP_SH_REL, plt_pkg::OP_EX_REL: n_state = plt_pkg::ST_RDSLOT;
                        plt_pkg::OP_PRUNE: begin
                            n_state = i_stat.live_ge_min ? plt_pkg::ST_SCAN
                                                         : plt_pkg::ST_UPDATE;
                        end
                        default: n_state = plt_pkg::ST_UPDATE;
                    endcase
                end
            end
            plt_pkg::ST_RDSLOT: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_slot = 1'b1;
                n_state       = plt_pkg::ST_LAST;
            end
            plt_pkg::ST_SCAN: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_cnt;
                if (r_cnt == LAST_IDX) begin
                    n_state = plt_pkg::ST_LAST;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            // data of the final read lands here
            plt_pkg::ST_LAST: begin
                n_state = plt_pkg::ST_UPDATE;
            end
            plt_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = plt_pkg::ST_RESP;
            end
            plt_pkg::ST_RESP: begin
                if (i_out_ready) begin
                    n_state = plt_pkg::ST_IDLE;
                end
            end
            default: n_state = plt_pkg::ST_IDLE;
        endcase
    end

    `PLT_ASSERT_NEXT(a_update_to_resp, i_clk, i_rst_n, r_state == plt_pkg::ST_UPDATE,
        r_state == plt_pkg::ST_RESP, "update not followed by response")
    `PLT_ASSERT_NEXT(a_resp_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid, "result dropped while stalled")
    `PLT_ASSERT_NEXT(a_scan_ends, i_clk, i_rst_n,
        r_state == plt_pkg::ST_SCAN && r_cnt == LAST_IDX,
        r_state == plt_pkg::ST_LAST, "scan ran past last entry")
    `PLT_ASSERT_SAME(a_no_read_idle, i_clk, i_rst_n, o_in_ready,
        !o_cmd.rd_en && !o_cmd.update, "table access while idle")

endmodule

// ===== src/plt_dp.sv =====
// datapath of the prefix lock table: entry ram, valid bits, scan capture, update
// depends on plt_pkg and plt_ram
`timescale 1ns / 1ps

module plt_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  plt_pkg::t_in   i_in_data,
    input  plt_pkg::t_cmd  i_cmd,
    output plt_pkg::t_stat o_stat,
    output plt_pkg::t_out  o_out_data
);

    localparam int N = plt_pkg::TABLE_ENTRIES;
    localparam int W = plt_pkg::IDX_W;
    localparam int L = plt_pkg::LIVE_W;

    plt_pkg::t_in    r_item;
    plt_pkg::t_out   r_out, n_out;
    plt_pkg::t_entry r_hrec, n_hrec;
    plt_pkg::t_entry rec, wrec;
    logic [N-1:0]    r_valid, n_valid;
    logic [L-1:0]    r_live, n_live;
    logic [6:0]      r_pruned, n_pruned;
    logic            r_hit, n_hit;
    logic [W-1:0]    r_hidx, n_hidx;
    logic            r_free_found, n_free_found;
    logic [W-1:0]    r_free_idx, n_free_idx;
    logic            r_dv;
    logic [W-1:0]    r_daddr;
    logic [W-1:0]    rd_addr, waddr;
    logic            we;
    logic [plt_pkg::ENTRY_W-1:0] rdata;
    logic [W-1:0]    slot_idx;
    logic            slot_ok;

    assign rd_addr  = i_cmd.rd_slot ? slot_idx : i_cmd.rd_addr;
    assign rec      = plt_pkg::t_entry'(rdata);
    assign slot_idx = W'(r_item.slot);
    assign slot_ok  = (32'(r_item.slot) < N);

    plt_ram #(.WIDTH(plt_pkg::ENTRY_W), .DEPTH(N)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wrec),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_live  <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_live  <= n_live;
            r_dv    <= i_cmd.rd_en;
        end
        r_daddr      <= rd_addr;
        r_out        <= n_out;
        r_pruned     <= n_pruned;
        r_hit        <= n_hit;
        r_hidx       <= n_hidx;
        r_hrec       <= n_hrec;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
    end

    always_comb begin
        n_valid      = r_valid;
        n_live       = r_live;
        n_out        = r_out;
        n_pruned     = r_pruned;
        n_hit        = r_hit;
        n_hidx       = r_hidx;
        n_hrec       = r_hrec;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        we           = 1'b0;
        waddr        = r_daddr;
        wrec         = rec;

        if (i_cmd.capture) begin
            n_pruned     = '0;
            n_hit        = 1'b0;
            n_free_found = 1'b0;
        end

        // one entry of read data per cycle
        if (r_dv) begin
            case (r_item.opcode)
                plt_pkg::OP_PRUNE: begin
                    if (r_valid[r_daddr] && r_item.horizon > rec.end_seq) begin
                        if (rec.refcount != '0) begin
                            wrec.stale = 1'b0;
                            we         = 1'b1;
                        end else if (!rec.stale) begin
                            wrec.stale = 1'b1;
                            we         = 1'b1;
                        end else begin
                            n_valid[r_daddr] = 1'b0;
                            n_live           = n_live - 1'b1;
                            n_pruned         = n_pruned + 1'b1;
                        end
                    end
                end
                plt_pkg::OP_SH_REL, plt_pkg::OP_EX_REL: begin
                    n_hrec = rec;
                end
                default: begin
                    if (r_valid[r_daddr] && rec.key == r_item.key_hash) begin
                        n_hit  = 1'b1;
                        n_hidx = r_daddr;
                        n_hrec = rec;
                    end
                    if (!r_valid[r_daddr] && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_daddr;
                    end
                end
            endcase
        end

        if (i_cmd.update) begin
            n_out.status       = plt_pkg::STS_INVALID;
            n_out.granted_slot = '0;
            n_out.pruned_count = '0;
            wrec               = r_hrec;
            waddr              = r_hidx;
            case (r_item.opcode)
                plt_pkg::OP_SH_ACQ, plt_pkg::OP_EX_ACQ: begin
                    if (r_item.opcode == plt_pkg::OP_EX_ACQ && r_item.holds_shared &&
                        !(slot_ok && r_hit && r_hidx == slot_idx)) begin
                        n_out.status = plt_pkg::STS_INVALID;
                    end else if (r_hit) begin
                        if (r_item.opcode == plt_pkg::OP_SH_ACQ) begin
                            if (r_hrec.exclusive || r_item.txn_start <= r_hrec.end_excl) begin
                                n_out.status = plt_pkg::STS_CANCELED;
                            end else if (r_hrec.refcount == '1) begin
                                n_out.status = plt_pkg::STS_BUSY;
                            end else begin
                                wrec.refcount      = r_hrec.refcount + 1'b1;
                                wrec.stale         = 1'b0;
                                we                 = 1'b1;
                                n_out.status       = plt_pkg::STS_OK;
                                n_out.granted_slot = 6'(r_hidx);
                            end
                        end else begin
                            if (r_item.txn_start <= r_hrec.end_seq ||
                                r_item.txn_start <= r_hrec.end_excl) begin
                                n_out.status = plt_pkg::STS_CANCELED;
                            end else if (r_hrec.refcount != '0) begin
                                if (r_item.holds_shared && r_hidx == slot_idx &&
                                    r_hrec.refcount == plt_pkg::REFCOUNT_BITS'(1) &&
                                    !r_hrec.exclusive) begin
                                    wrec.exclusive     = 1'b1;
                                    wrec.stale         = 1'b0;
                                    we                 = 1'b1;
                                    n_out.status       = plt_pkg::STS_OK;
                                    n_out.granted_slot = 6'(r_hidx);
                                end else begin
                                    n_out.status = plt_pkg::STS_BUSY;
                                end
                            end else begin
                                wrec.refcount      = plt_pkg::REFCOUNT_BITS'(1);
                                wrec.exclusive     = 1'b1;
                                wrec.stale         = 1'b0;
                                we                 = 1'b1;
                                n_out.status       = plt_pkg::STS_OK;
                                n_out.granted_slot = 6'(r_hidx);
                            end
                        end
                    end else if (!r_free_found) begin
                        n_out.status = plt_pkg::STS_NOSPACE;
                    end else begin
                        // new entry in the lowest free index
                        wrec.key              = r_item.key_hash;
                        wrec.refcount         = plt_pkg::REFCOUNT_BITS'(1);
                        wrec.exclusive        = (r_item.opcode == plt_pkg::OP_EX_ACQ);
                        wrec.stale            = 1'b0;
                        wrec.end_seq          = '0;
                        wrec.end_excl         = '0;
                        waddr                 = r_free_idx;
                        we                    = 1'b1;
                        n_valid[r_free_idx]   = 1'b1;
                        n_live                = r_live + 1'b1;
                        n_out.status          = plt_pkg::STS_OK;
                        n_out.granted_slot    = 6'(r_free_idx);
                    end
                end
                plt_pkg::OP_SH_REL, plt_pkg::OP_EX_REL: begin
                    waddr = slot_idx;
                    if (slot_ok && r_valid[slot_idx] && r_hrec.refcount != '0 &&
                        (r_item.opcode == plt_pkg::OP_SH_REL || r_hrec.exclusive)) begin
                        wrec.refcount = r_hrec.refcount - 1'b1;
                        if (r_item.opcode == plt_pkg::OP_SH_REL) begin
                            if (r_item.txn_end > r_hrec.end_seq) begin
                                wrec.end_seq = r_item.txn_end;
                            end
                        end else begin
                            wrec.exclusive = 1'b0;
                            wrec.end_seq   = r_item.txn_end;
                            wrec.end_excl  = r_item.txn_end;
                        end
                        we                 = 1'b1;
                        n_out.status       = plt_pkg::STS_OK;
                        n_out.granted_slot = r_item.slot;
                    end
                end
                plt_pkg::OP_PRUNE: begin
                    n_out.status       = plt_pkg::STS_OK;
                    n_out.pruned_count = r_pruned;
                end
                default: n_out.status = plt_pkg::STS_INVALID;
            endcase
        end
    end

    assign o_stat.live_ge_min = (32'(r_live) >= plt_pkg::PRUNE_MIN_LIVE);
    assign o_out_data         = r_out;

endmodule

// ===== src/prefix_lock_table_top.sv =====
// Prefix lock table: shared/exclusive locks keyed by 64-bit prefix hashes.
// Input channel takes one operation beat (acquire, release, prune); output
// channel returns one result beat (status, granted slot, pruned count) per
// operation. Both channels are valid/ready.
// Entries live in a 64-entry ram read one entry per cycle; valid bits and
// the live count are flops.
// From accept to result valid: acquire and an effective prune walk all 64
// entries; release reads its slot; a prune with fewer than two live
// entries or an unknown opcode reads no entry. Each ends with an update step.
// One operation is in flight at a time: the next beat is taken the cycle
// after the result is taken.
// Reset (synchronous, active low) empties the table at once.
// While the receiver stalls the result beat holds and no input is taken.
// depends on plt_pkg, plt_ctrl, plt_dp
`timescale 1ns / 1ps

module prefix_lock_table_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  plt_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output plt_pkg::t_out o_out_data
);

    plt_pkg::t_cmd  cmd;
    plt_pkg::t_stat stat;

    plt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_in_data.opcode),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    plt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule
